@@ hdl/hcbd_pkg.sv @@
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; compiled first.
package hcbd_pkg;

	// Size line limits and default counter width
	localparam int LINE_CHARS     = 15;
	localparam int LCNT_BITS      = 4;
	localparam int SIZE_BITS_DEF  = 32;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH    = 2;

	// Character codes seen on the size line
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	// Parse phase
	typedef enum logic [2:0] {
		PH_LINE  = 3'd0,
		PH_TERM  = 3'd1,
		PH_DATA  = 3'd2,
		PH_TRAIL = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	// Digit scan state on the size line
	typedef enum logic [1:0] {
		DG_LEAD   = 2'd0,
		DG_DIGITS = 2'd1,
		DG_STOP   = 2'd2
	} digits_t;

	// End of message status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TRUNC = 2'd1,
		ST_OVF   = 2'd2
	} status_t;

	// One classified input beat, as handed from front to back
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
		logic       is_eol;   // CR or LF
		logic       is_blank; // space or tab
		logic       is_hex;
		logic [3:0] hex_val;
	} item_t;

endpackage

@@ hdl/hcbd_in_if.sv @@
// Input channel of the chunked body decoder: one raw body byte per beat.
// Standalone interface; no dependencies.
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, in_byte, is_last, input ready);
	modport sink   (input valid, in_byte, is_last, output ready);
endinterface

@@ hdl/hcbd_out_if.sv @@
// Output channel of the chunked body decoder: payload byte and end status.
// Standalone interface; no dependencies.
interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       message_end;
	logic [1:0] end_status;

	modport source (output valid, data_byte, has_data, message_end, end_status, input ready);
	modport sink   (input valid, data_byte, has_data, message_end, end_status, output ready);
endinterface

@@ hdl/http_chunked_body_decoder_core.sv @@
// HTTP chunked body decoder, top level: front, queue and back wired together.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if, hcbd_front, hcbd_queue, hcbd_back.
//
// Takes one body byte per beat on body (is_last on the final byte) and returns at most one
// beat on decoded per input byte: a payload byte, the end-of-message status, or both. Size
// lines, their terminators and the chunk trailers give no beat unless they carry is_last.
// The block sustains one byte per clock while the sink accepts: the front classifies a
// byte in the cycle it is taken, a two-entry queue holds it, and the back parser updates
// its state for one byte per cycle and loads a registered result from it.
// Throughput is set by the single parser step per cycle; a stalled sink backs up the queue
// and then the input. SIZE_BITS sets the chunk size counter width; a longer size reports
// overflow.
module http_chunked_body_decoder_core #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hcbd_in_if.sink     body,
	hcbd_out_if.source  decoded
);
	import hcbd_pkg::*;

	item_t push_item;
	item_t pop_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	hcbd_front u_front (
		.body (body),
		.full (full),
		.push (push),
		.item (push_item)
	);

	hcbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.pop     (pop),
		.rd_item (pop_item),
		.empty   (empty)
	);

	hcbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (pop_item),
		.empty   (empty),
		.pop     (pop),
		.decoded (decoded)
	);

endmodule

@@ hdl/hcbd_front.sv @@
// Front end: accepts body bytes and classifies them for the parser.
// Depends on hcbd_pkg and hcbd_in_if.
module hcbd_front (
	hcbd_in_if.sink        body,
	input  logic           full,
	output logic           push,
	output hcbd_pkg::item_t item
);
	import hcbd_pkg::*;

	// Take a beat whenever the queue has room
	assign body.ready = !full;
	assign push       = body.valid && !full;

	// Classify the byte: line end, blank, hex digit and its value
	always_comb begin
		item.in_byte  = body.in_byte;
		item.is_last  = body.is_last;
		item.is_eol   = (body.in_byte == CH_CR) || (body.in_byte == CH_LF);
		item.is_blank = (body.in_byte == CH_SP) || (body.in_byte == CH_TAB);
		item.is_hex   = 1'b0;
		item.hex_val  = 4'd0;
		if (body.in_byte >= 8'h30 && body.in_byte <= 8'h39) begin
			item.is_hex  = 1'b1;
			item.hex_val = body.in_byte[3:0];
		end else if ((body.in_byte >= 8'h61 && body.in_byte <= 8'h66) ||
		             (body.in_byte >= 8'h41 && body.in_byte <= 8'h46)) begin
			// 'a'..'f' and 'A'..'F' share low bits 1..6
			item.is_hex  = 1'b1;
			item.hex_val = body.in_byte[3:0] + 4'd9;
		end
	end

endmodule

@@ hdl/hcbd_queue.sv @@
// Short queue of classified beats between front and back.
// Depends on hcbd_pkg.
module hcbd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hcbd_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output hcbd_pkg::item_t rd_item,
	output logic            empty
);
	import hcbd_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	item_t               slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full    = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	// Payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/hcbd_back.sv @@
// Back end: chunk parser state machine and registered result beat.
// Depends on hcbd_pkg and hcbd_out_if.
module hcbd_back #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hcbd_pkg::item_t item,
	input  logic            empty,
	output logic            pop,
	hcbd_out_if.source      decoded
);
	import hcbd_pkg::*;

	phase_t                phase_q, phase_n;
	logic [LCNT_BITS-1:0]  lcnt_q, lcnt_n;
	logic [SIZE_BITS-1:0]  acc_q, acc_n;
	digits_t               dig_q, dig_n;
	logic                  skip_q, skip_n;
	logic [SIZE_BITS-1:0]  rem_q, rem_n;
	logic                  ovf_q, ovf_n;

	logic                  data_n;
	status_t               status_n;
	logic                  emit;

	logic                  out_valid_q;
	logic [7:0]            data_byte_q;
	logic                  has_data_q;
	logic                  message_end_q;
	status_t               end_status_q;

	// Take a queued beat when the result register is free or draining
	assign pop = !empty && (!out_valid_q || decoded.ready);

	// Next parser state
	always_comb begin
		logic [LCNT_BITS-1:0] cnt_inc;
		logic [SIZE_BITS-1:0] rem_dec;
		phase_n = phase_q;
		lcnt_n  = lcnt_q;
		acc_n   = acc_q;
		dig_n   = dig_q;
		skip_n  = skip_q;
		rem_n   = rem_q;
		ovf_n   = ovf_q;
		cnt_inc = lcnt_q + 1'b1;
		rem_dec = rem_q - 1'b1;
		unique case (phase_q)
			PH_LINE: begin
				if (item.is_eol) begin
					phase_n = PH_TERM;
					skip_n  = 1'b1;
				end else begin
					// Digit scan: skip leading blanks, stop at first non-hex
					if ((dig_q == DG_LEAD) && item.is_blank) begin
						dig_n = dig_q;
					end else if (dig_q == DG_STOP) begin
						dig_n = dig_q;
					end else if (!item.is_hex) begin
						dig_n = DG_STOP;
					end else begin
						dig_n = DG_DIGITS;
						if (!ovf_q) begin
							if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) begin
								ovf_n = 1'b1;
							end else begin
								acc_n = {acc_q[SIZE_BITS-5:0], item.hex_val};
							end
						end
					end
					lcnt_n = cnt_inc;
					if (cnt_inc >= LCNT_BITS'(LINE_CHARS) || cnt_inc == '0) begin
						phase_n = PH_TERM;
						skip_n  = 1'b0;
					end
				end
			end
			PH_TERM: begin
				if (!skip_q) begin
					skip_n = 1'b1;
				end else if (ovf_q || acc_q == '0) begin
					phase_n = PH_DONE;
				end else begin
					rem_n   = acc_q;
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					phase_n = PH_TRAIL;
					skip_n  = 1'b0;
				end
			end
			PH_TRAIL: begin
				if (!skip_q) begin
					skip_n = 1'b1;
				end else begin
					phase_n = PH_LINE;
					skip_n  = 1'b0;
					lcnt_n  = '0;
					acc_n   = '0;
					dig_n   = DG_LEAD;
					ovf_n   = 1'b0;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
		// The last beat of a message returns the parser state to reset
		if (item.is_last) begin
			phase_n = PH_LINE;
			lcnt_n  = '0;
			acc_n   = '0;
			dig_n   = DG_LEAD;
			skip_n  = 1'b0;
			rem_n   = '0;
			ovf_n   = 1'b0;
		end
	end

	// Result of this beat: payload flag and status if the message ends here
	always_comb begin
		data_n   = 1'b0;
		status_n = ovf_q ? ST_OVF : ST_OK;
		unique case (phase_q)
			PH_LINE: begin
				status_n = (!item.is_eol && dig_q != DG_STOP && !item.is_blank &&
				            item.is_hex && (ovf_q || acc_q[SIZE_BITS-1 -: 4] != 4'd0)) ||
				           ovf_q ? ST_OVF : ST_OK;
			end
			PH_TERM: begin
				if (skip_q && !ovf_q && acc_q != '0) begin
					status_n = ST_TRUNC;
				end
			end
			PH_DATA: begin
				data_n   = 1'b1;
				status_n = ((rem_q - 1'b1) == '0) ? ST_OK : ST_TRUNC;
			end
			PH_TRAIL: begin
				status_n = ST_OK;
			end
			default: begin
				status_n = ovf_q ? ST_OVF : ST_OK;
			end
		endcase
		emit = data_n || item.is_last;
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE;
			lcnt_q  <= '0;
			acc_q   <= '0;
			dig_q   <= DG_LEAD;
			skip_q  <= 1'b0;
			rem_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (pop) begin
			phase_q <= phase_n;
			lcnt_q  <= lcnt_n;
			acc_q   <= acc_n;
			dig_q   <= dig_n;
			skip_q  <= skip_n;
			rem_q   <= rem_n;
			ovf_q   <= ovf_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			data_byte_q   <= data_n ? item.in_byte : 8'd0;
			has_data_q    <= data_n;
			message_end_q <= item.is_last;
			end_status_q  <= item.is_last ? status_n : ST_OK;
		end
	end

	assign decoded.valid       = out_valid_q;
	assign decoded.data_byte   = data_byte_q;
	assign decoded.has_data    = has_data_q;
	assign decoded.message_end = message_end_q;
	assign decoded.end_status  = end_status_q;

endmodule

@@ tb/http_chunked_body_decoder_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for http_chunked_body_decoder_core: random chunked bodies in,
// decoded beats checked against a cycle-free model of the chunk parser.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and the decoder RTL.
module http_chunked_body_decoder_core_test;
	import hcbd_pkg::*;

	localparam int SIZE_W       = SIZE_BITS_DEF;
	localparam int ITEM_TARGET  = 1500;
	localparam int IDLE_LIMIT   = 3000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} body_beat_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       message_end;
		status_t    end_status;
	} decoded_beat_t;

	logic clk;
	logic arst_n;

	hcbd_in_if  body_if ();
	hcbd_out_if decoded_if ();

	http_chunked_body_decoder_core #(
		.SIZE_BITS(SIZE_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body_if),
		.decoded (decoded_if)
	);

	// Stimulus and scoreboard storage
	body_beat_t    body_bytes[$];
	logic [7:0]    msg_bytes[$];
	decoded_beat_t beats_due[$];
	int            mismatches;
	int            results_seen;
	int            idle_cycles;
	logic          in_taken;

	// Parser state mirror
	phase_t            phase;
	logic [3:0]        line_cnt;
	logic [SIZE_W-1:0] size_acc;
	digits_t           dig;
	logic              skip;
	logic [SIZE_W-1:0] remaining;
	logic              size_ovf;

	// Sender and receiver pacing
	int gap_left;
	int burst_left;
	int seg_left;
	int stall_pct;
	int hold_left;
	int holds_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic clear_parser();
		phase     = PH_LINE;
		skip      = 1'b0;
		remaining = '0;
		line_cnt  = '0;
		size_acc  = '0;
		dig       = DG_LEAD;
		size_ovf  = 1'b0;
	endtask

	// Advance the parser mirror by one body byte; queue the decoded beat it produces
	task automatic decode_step(input logic [7:0] b, input logic last);
		logic          hit_data;
		status_t       st;
		int            hv;
		decoded_beat_t beat;
		hit_data = 1'b0;
		st = size_ovf ? ST_OVF : ST_OK;
		if (b >= "0" && b <= "9")
			hv = b - "0";
		else if (b >= "a" && b <= "f")
			hv = b - "a" + 10;
		else if (b >= "A" && b <= "F")
			hv = b - "A" + 10;
		else
			hv = -1;
		case (phase)
			PH_LINE: begin
				if (b == CH_CR || b == CH_LF) begin
					phase = PH_TERM;
					skip  = 1'b1;
				end else begin
					// leading blanks skipped, digits until the first non-hex char
					if (dig == DG_LEAD && (b == CH_SP || b == CH_TAB)) begin
					end else if (dig == DG_STOP) begin
					end else if (hv < 0) begin
						dig = DG_STOP;
					end else begin
						dig = DG_DIGITS;
						if (!size_ovf) begin
							if (size_acc[SIZE_W-1 -: 4] != 4'd0)
								size_ovf = 1'b1;
							else
								size_acc = {size_acc[SIZE_W-5:0], hv[3:0]};
						end
					end
					line_cnt = line_cnt + 4'd1;
					if (line_cnt >= LINE_CHARS || line_cnt == 4'd0) begin
						phase = PH_TERM;
						skip  = 1'b0;
					end
				end
				st = size_ovf ? ST_OVF : ST_OK;
			end
			PH_TERM: begin
				if (!skip) begin
					skip = 1'b1;
				end else if (size_ovf) begin
					phase = PH_DONE;
					st    = ST_OVF;
				end else if (size_acc == '0) begin
					phase = PH_DONE;
					st    = ST_OK;
				end else begin
					remaining = size_acc;
					phase     = PH_DATA;
					st        = ST_TRUNC;
				end
			end
			PH_DATA: begin
				hit_data  = 1'b1;
				remaining = remaining - 1'b1;
				if (remaining == '0) begin
					phase = PH_TRAIL;
					skip  = 1'b0;
					st    = ST_OK;
				end else begin
					st = ST_TRUNC;
				end
			end
			PH_TRAIL: begin
				if (!skip) begin
					skip = 1'b1;
				end else begin
					phase    = PH_LINE;
					skip     = 1'b0;
					line_cnt = '0;
					size_acc = '0;
					dig      = DG_LEAD;
					size_ovf = 1'b0;
				end
				st = ST_OK;
			end
			default: st = size_ovf ? ST_OVF : ST_OK;
		endcase
		if (hit_data || last) begin
			beat.data_byte   = hit_data ? b : 8'h00;
			beat.has_data    = hit_data;
			beat.message_end = last;
			beat.end_status  = last ? st : ST_OK;
			beats_due.push_back(beat);
		end
		if (last)
			clear_parser();
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	// Size line: optional blanks, hex in mixed case, optional extension, some terminator
	task automatic put_size_line(int unsigned sz);
		string      digits;
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				msg_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
		if ($urandom_range(0, 5) == 0)
			msg_bytes.push_back("0");
		digits = $sformatf("%0h", sz);
		for (int i = 0; i < digits.len(); i++) begin
			c = digits[i];
			if (c >= "a" && $urandom_range(0, 1))
				c = c - 8'h20;
			msg_bytes.push_back(c);
		end
		if ($urandom_range(0, 5) == 0)
			put_text(";ext=1");
		case ($urandom_range(0, 7))
			0: begin
				msg_bytes.push_back(CH_LF);
				msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
			1: begin
				msg_bytes.push_back(CH_CR);
				msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: put_text("\r\n");
		endcase
	endtask

	task automatic put_chunk(int unsigned sz);
		put_size_line(sz);
		repeat (sz)
			msg_bytes.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0) begin
			msg_bytes.push_back(8'($urandom_range(0, 255)));
			msg_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			put_text("\r\n");
		end
	endtask

	// Move the built message to the send queue, flagging the final byte; maybe cut it short
	task automatic flush_message(bit may_cut);
		int n;
		n = msg_bytes.size();
		if (may_cut && $urandom_range(0, 3) == 0)
			n = $urandom_range(1, msg_bytes.size());
		for (int i = 0; i < n; i++)
			body_bytes.push_back('{in_byte: msg_bytes[i], is_last: (i == n - 1)});
		msg_bytes.delete();
	endtask

	task automatic gen_message();
		string hexchars;
		int    kind;
		hexchars = "0123456789abcdefABCDEF";
		kind = $urandom_range(0, 9);
		if (kind <= 8) begin
			repeat ($urandom_range(kind <= 5 ? 1 : 0, 3))
				put_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(17, 200)
				                                      : $urandom_range(1, 16));
		end
		case (kind)
			6: begin
				// size line wider than the counter
				msg_bytes.push_back(hexchars[$urandom_range(1, 21)]);
				repeat ($urandom_range(8, 12))
					msg_bytes.push_back(hexchars[$urandom_range(0, 21)]);
				put_text("\r\n");
			end
			7: begin
				// lines that carry no usable size
				case ($urandom_range(0, 4))
					0: put_text("zz\r\n");
					1: put_text("\r\n");
					2: put_text("0x1f\r\n");
					3: put_text("-5\r\n");
					default: put_text(" \t;x\r\n");
				endcase
			end
			8: begin
				// line runs to the character limit without a terminator
				msg_bytes.push_back(hexchars[$urandom_range(1, 9)]);
				repeat (LINE_CHARS - 1) begin
					case ($urandom_range(0, 3))
						0: msg_bytes.push_back(";");
						1: msg_bytes.push_back("z");
						2: msg_bytes.push_back("=");
						default: msg_bytes.push_back("g");
					endcase
				end
				msg_bytes.push_back(8'($urandom_range(0, 255)));
				msg_bytes.push_back(8'($urandom_range(0, 255)));
				repeat (msg_bytes[msg_bytes.size() - 17] - "0")
					msg_bytes.push_back(8'($urandom_range(0, 255)));
				put_text("\r\n0\r\n");
			end
			9: begin
				repeat ($urandom_range(1, 20))
					msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: put_text("0\r\n");
		endcase
		if (kind != 9) begin
			if ($urandom_range(0, 1))
				put_text("\r\n");
			repeat ($urandom_range(0, 3))
				msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
		flush_message(1'b1);
	endtask

	// Sample both channels, run the mirror, compare, and watch for a hang
	always @(posedge clk) begin
		decoded_beat_t want;
		logic          out_taken;
		in_taken  = body_if.valid && body_if.ready;
		out_taken = decoded_if.valid && decoded_if.ready;
		if (arst_n) begin
			if (in_taken)
				decode_step(body_if.in_byte, body_if.is_last);
			if (out_taken) begin
				results_seen++;
				if (beats_due.size() == 0) begin
					report_mismatch("decoded beat with nothing expected");
				end else begin
					want = beats_due.pop_front();
					if (decoded_if.has_data !== want.has_data)
						report_mismatch($sformatf("has_data %b, want %b",
							decoded_if.has_data, want.has_data));
					if (decoded_if.data_byte !== want.data_byte)
						report_mismatch($sformatf("data_byte %h, want %h",
							decoded_if.data_byte, want.data_byte));
					if (decoded_if.message_end !== want.message_end)
						report_mismatch($sformatf("message_end %b, want %b",
							decoded_if.message_end, want.message_end));
					if (decoded_if.end_status !== want.end_status)
						report_mismatch($sformatf("end_status %0d, want %0d",
							decoded_if.end_status, want.end_status));
				end
			end
			if (in_taken || out_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Body driver: bursts of beats with random gaps between them
	always @(negedge clk) begin
		body_beat_t nxt;
		if (!arst_n) begin
			body_if.valid <= 1'b0;
		end else if (body_if.valid && !in_taken) begin
			// beat still offered, hold it
		end else if (gap_left > 0) begin
			body_if.valid <= 1'b0;
			gap_left--;
		end else if (body_bytes.size() != 0) begin
			nxt = body_bytes.pop_front();
			body_if.valid   <= 1'b1;
			body_if.in_byte <= nxt.in_byte;
			body_if.is_last <= nxt.is_last;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 60);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end else begin
			body_if.valid <= 1'b0;
		end
	end

	// Receiver: segments of varying stall rate, plus two long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			decoded_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			decoded_if.ready <= 1'b0;
			hold_left--;
		end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 150 : 700)) begin
			hold_left = LONG_HOLD;
			holds_done++;
			decoded_if.ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 200);
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end else begin
				seg_left--;
			end
			decoded_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		body_if.valid      = 1'b0;
		body_if.in_byte    = 8'h00;
		body_if.is_last    = 1'b0;
		decoded_if.ready   = 1'b0;
		arst_n             = 1'b0;
		mismatches         = 0;
		results_seen       = 0;
		idle_cycles        = 0;
		in_taken           = 1'b0;
		gap_left           = 0;
		burst_left         = 0;
		seg_left           = 0;
		stall_pct          = 0;
		hold_left          = 0;
		holds_done         = 0;
		clear_parser();

		// Directed: extreme payload bytes with a clean end, an oversize line, a lone byte
		put_text("2\r\n");
		msg_bytes.push_back(8'h00);
		msg_bytes.push_back(8'hFF);
		put_text("\r\n0\r\n\r\n");
		flush_message(1'b0);
		put_text("123456789\r\n");
		flush_message(1'b0);
		msg_bytes.push_back(8'h00);
		flush_message(1'b0);

		while (body_bytes.size() < ITEM_TARGET)
			gen_message();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (body_bytes.size() != 0 || body_if.valid || beats_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
